FILE: sv/uesd_pkg.sv
// ----------------------------------------------------------------------------
// uesd_pkg
// Types, character codes, status codes and the hex digit decoder shared by
// the blocks of the unicode escape decoder.
// ----------------------------------------------------------------------------
package uesd_pkg;

	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_UP_U = 8'h55;
	localparam logic [7:0] CH_LO_U = 8'h75;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NO_BSL  = 3'd1;
	localparam logic [2:0] ST_BAD_PFX = 3'd2;
	localparam logic [2:0] ST_BAD_HEX = 3'd3;
	localparam logic [2:0] ST_NO_LBSL = 3'd4;
	localparam logic [2:0] ST_NO_LU   = 3'd5;

	typedef struct packed {
		logic [31:0] code_point;
		logic [2:0]  status;
	} result_t;

	typedef struct packed {
		logic    has_result;
		result_t res;
	} step_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nibble;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.ok     = 1'b1;
		h.nibble = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.nibble = b[3:0];
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			h.nibble = b[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

FILE: sv/uesd_in_reg.sv
// ----------------------------------------------------------------------------
// uesd_in_reg
// Input register: holds one byte until the parser steps on it.
// ----------------------------------------------------------------------------
module uesd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       fire,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	logic accept;

	assign in_stall = valid_s1 && !fire;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
		end
	end
endmodule

FILE: sv/uesd_parser.sv
// ----------------------------------------------------------------------------
// uesd_parser
// Escape parser state and the single step logic for one byte.
// ----------------------------------------------------------------------------
module uesd_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     byte_s1,
	output uesd_pkg::step_t step
);
	import uesd_pkg::*;

	typedef enum logic [5:0] {
		PH_BSL   = 6'b000001,
		PH_PFX   = 6'b000010,
		PH_HEX32 = 6'b000100,
		PH_LBSL  = 6'b001000,
		PH_LU    = 6'b010000,
		PH_HEX16 = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  digits_q, digits_d;
	logic [31:0] acc_q, acc_d;
	logic [15:0] high_q, high_d;
	logic        low_q, low_d;
	hex_t        hx;
	logic [31:0] shifted;
	logic [3:0]  dec;
	logic [31:0] pair;

	assign hx      = hex_decode(byte_s1);
	assign shifted = {acc_q[27:0], hx.nibble};
	assign dec     = (digits_q != 4'd0) ? digits_q - 4'd1 : 4'd0;
	assign pair    = 32'h0001_0000 + (({16'd0, high_q} - 32'h0000_D800) << 10)
		+ ({16'd0, shifted[15:0]} - 32'h0000_DC00);

	always_comb begin
		phase_d  = phase_q;
		digits_d = digits_q;
		acc_d    = acc_q;
		high_d   = high_q;
		low_d    = low_q;
		step     = '0;
		case (phase_q)
			PH_PFX: begin
				if (byte_s1 == CH_UP_U) begin
					phase_d  = PH_HEX32;
					digits_d = 4'd8;
					acc_d    = '0;
				end else if (byte_s1 == CH_LO_U) begin
					phase_d  = PH_HEX16;
					digits_d = 4'd4;
					acc_d    = '0;
					low_d    = 1'b0;
				end else begin
					step.has_result = 1'b1;
					step.res.status = ST_BAD_PFX;
				end
			end
			PH_HEX32, PH_HEX16: begin
				if (!hx.ok) begin
					step.has_result = 1'b1;
					step.res.status = ST_BAD_HEX;
				end else begin
					acc_d    = shifted;
					digits_d = dec;
					if (dec == 4'd0) begin
						if (phase_q == PH_HEX32) begin
							step.has_result     = 1'b1;
							step.res.code_point = shifted;
						end else if (low_q) begin
							step.has_result     = 1'b1;
							step.res.code_point = pair;
						end else if (shifted[15:10] == 6'b110110) begin
							high_d   = shifted[15:0];
							phase_d  = PH_LBSL;
							digits_d = 4'd0;
							acc_d    = '0;
						end else begin
							step.has_result     = 1'b1;
							step.res.code_point = {16'd0, shifted[15:0]};
						end
					end
				end
			end
			PH_LBSL: begin
				if (byte_s1 == CH_BSL) begin
					phase_d = PH_LU;
				end else begin
					step.has_result = 1'b1;
					step.res.status = ST_NO_LBSL;
				end
			end
			PH_LU: begin
				if (byte_s1 == CH_LO_U) begin
					phase_d  = PH_HEX16;
					digits_d = 4'd4;
					acc_d    = '0;
					low_d    = 1'b1;
				end else begin
					step.has_result = 1'b1;
					step.res.status = ST_NO_LU;
				end
			end
			default: begin
				if (byte_s1 == CH_BSL) begin
					phase_d = PH_PFX;
				end else begin
					step.has_result = 1'b1;
					step.res.status = ST_NO_BSL;
				end
			end
		endcase
		// every result ends the escape
		if (step.has_result) begin
			phase_d  = PH_BSL;
			digits_d = 4'd0;
			acc_d    = '0;
			low_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BSL;
			digits_q <= 4'd0;
			acc_q    <= '0;
			high_q   <= '0;
			low_q    <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			digits_q <= digits_d;
			acc_q    <= acc_d;
			high_q   <= high_d;
			low_q    <= low_d;
		end
	end
endmodule

FILE: sv/uesd_out_reg.sv
// ----------------------------------------------------------------------------
// uesd_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module uesd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  uesd_pkg::result_t res,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      code_point,
	output logic [2:0]       status
);
	import uesd_pkg::*;

	result_t res_q;

	assign code_point = res_q.code_point;
	assign status     = res_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end
endmodule

FILE: sv/unicode_escape_decoder.sv
// ----------------------------------------------------------------------------
// unicode_escape_decoder
// Decodes backslash-u and backslash-U escape text into code points, joining
// surrogate pairs, with a status code for each malformed escape.
//
//   channel  dir  handshake             fields
//   in       in   in_valid / in_stall   in_byte
//   out      out  out_valid / out_stall code_point, status
//
// one byte per cycle sustained while the result register is not held under
// out_stall; each byte passes the input register, one parser step and the
// result register, and a byte that ends an escape loads its result there
// reset clears the parser to expecting a backslash and empties both registers
// in_stall rises only while the result register holds an item under out_stall
// and the waiting byte would produce another result
// ----------------------------------------------------------------------------
module unicode_escape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] code_point,
	output logic [2:0]  status
);
	import uesd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire;
	step_t      step;

	assign fire = valid_s1 && (!step.has_result || !out_valid || !out_stall);

	uesd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	uesd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.step    (step)
	);

	uesd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire && step.has_result),
		.res        (step.res),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.status     (status)
	);
endmodule

FILE: sv/uesd_checker.sv
// ----------------------------------------------------------------------------
// uesd_checker
// Port level checks of the unicode escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module uesd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] code_point,
	input logic [2:0]  status
);
	import uesd_pkg::*;

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_NO_LU))
		else $error("status code out of range");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (code_point == 32'd0))
		else $error("error item carries a code point");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output back pressure");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> in_valid)
		else $error("stalled input item withdrawn");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(code_point) && $stable(status)))
		else $error("stalled item changed");
endmodule

bind unicode_escape_decoder uesd_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.code_point (code_point),
	.status     (status)
);
